@@ hdl/hashed_sparse_weight_update_macros.svh @@
// assertion helpers for hashed_sparse_weight_update.sv
`ifndef HASHED_SPARSE_WEIGHT_UPDATE_MACROS_SVH
`define HASHED_SPARSE_WEIGHT_UPDATE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HSWU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HSWU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/hswu_pkg.sv @@
`default_nettype none

package hswu_pkg;

	// default depth of the weight store, as address bits
	localparam int WEIGHT_ADDR_BITS_DEF = 18;

	localparam int Q_W         = 32;
	localparam int FRAC_BITS   = 16;
	localparam int PROD_W      = 2 * Q_W;
	localparam int INC_W       = PROD_W - FRAC_BITS;
	localparam int MASK_W      = 18;
	localparam int ADDR_OUT_W  = 18;
	localparam int INDEX_W     = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	// func codes; any other code reads the weight
	localparam logic [1:0] FUNC_LINEAR = 2'd0;
	localparam logic [1:0] FUNC_QUAD   = 2'd1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_MASK = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_MULT  = 1'd1;

	localparam logic [MASK_W-1:0]  MASK_RESET      = 18'h3FFFF;
	localparam logic [INDEX_W-1:0] HASH_MULT_RESET = 32'd27942141;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]               func;
		logic [INDEX_W-1:0]       first_index;
		logic signed [Q_W-1:0]    first_value;
		logic [INDEX_W-1:0]       second_index;
		logic signed [Q_W-1:0]    second_value;
		logic signed [Q_W-1:0]    step_scale;
	} hswu_in_t;

	typedef struct packed {
		logic [ADDR_OUT_W-1:0]    entry_address;
		logic signed [Q_W-1:0]    weight_value;
		logic                     saturated;
	} hswu_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_MUL,
		ST_WRITE
	} hswu_state_t;

endpackage

`default_nettype wire

@@ hdl/hashed_sparse_weight_update.sv @@
`default_nettype none
`include "hashed_sparse_weight_update_macros.svh"

// Hashed sparse weight update. Holds 2^WEIGHT_ADDR_BITS signed Q16.16 weights in one
// synchronous memory and applies one feature (func 0), one feature pair (func 1) or a
// plain read (other codes) per input word, returning one output word with the masked
// address, the weight after the item and a saturation flag. Linear items add
// floor(step_scale*first_value/2^16); pair items hash their address as
// hash_multiplier*first_index + second_index, clip the first scaled product to 32 bits
// and add floor(that*second_value/2^16). The sum clips to the Q16.16 range; any
// clipping raises saturated. A zero step_scale leaves memory untouched. Each item passes
// through the sequencer states in order: the accepting cycle, address hash and first
// multiply, memory read, second multiply, then add, clip and write-back. The output
// word is loaded in write-back, and the next word is taken in the cycle after
// write-back, so no word is taken before the last one is written back and no
// forwarding is needed. A finished word may sit in the output register while the
// next item is accepted and worked on; if it is still held there, the next item
// waits in write-back until the output stall drops. After reset a clearing pass
// zeroes all 2^WEIGHT_ADDR_BITS entries (262144 by default), one entry per cycle;
// in_stall stays high meanwhile, configuration writes are taken at any time.
// Configuration: index 0 is index_mask, index 1 is hash_multiplier.
module hashed_sparse_weight_update
	import hswu_pkg::*;
#(
	parameter int WEIGHT_ADDR_BITS = WEIGHT_ADDR_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input channel
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire hswu_in_t               in_data,
	// output channel
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      hswu_out_t              out_data,
	// configuration writes
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW    = WEIGHT_ADDR_BITS;
	localparam int DEPTH = 1 << WEIGHT_ADDR_BITS;

	// control state
	hswu_state_t          state_q, state_d;
	logic [AW-1:0]        clr_addr_q;
	logic                 out_valid_q;
	logic [MASK_W-1:0]    index_mask_q;
	logic [INDEX_W-1:0]   hash_mult_q;

	// item registers
	hswu_in_t             item_q;
	logic [AW-1:0]        addr_q;
	logic signed [PROD_W-1:0] p1_q;
	logic signed [PROD_W-1:0] p2_q;
	logic                 sat1_q;
	logic signed [Q_W-1:0] rdata_q;
	hswu_out_t            out_q;

	// weight store, no reset: the clearing pass zeroes it
	logic [Q_W-1:0]       weight_mem [0:DEPTH-1];

	// datapath
	logic [INDEX_W-1:0]   hash_lo;
	logic [INDEX_W-1:0]   hashed;
	logic [INDEX_W-1:0]   mask_ext;
	logic [AW-1:0]        addr_d;
	logic signed [PROD_W-1:0] p1_d;
	logic signed [INC_W-1:0]  sh1;
	logic                 fits1;
	logic signed [Q_W-1:0] s_clip;
	logic signed [PROD_W-1:0] p2_d;
	logic signed [INC_W-1:0]  incr;
	logic signed [INC_W:0]    sum;
	logic                 fits2;
	logic signed [Q_W-1:0] new_w;
	logic                 do_update;
	logic                 sat_out;
	logic signed [Q_W-1:0] w_out;
	logic [INDEX_W-1:0]   addr_wide;

	// control outputs of the sequencer
	logic                 in_accept;
	logic                 out_free;
	logic                 out_load;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic signed [Q_W-1:0] mem_wdata;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// address hash, first stage: one 32x32 low-half multiply plus an add
	assign hash_lo  = hash_mult_q * item_q.first_index;
	assign hashed   = (item_q.func == FUNC_QUAD) ? hash_lo + item_q.second_index
	                                             : item_q.first_index;
	assign mask_ext = {{(INDEX_W - MASK_W){1'b0}}, index_mask_q};
	assign addr_d   = hashed[AW-1:0] & mask_ext[AW-1:0];

	// step times first feature value, full signed product
	assign p1_d = item_q.step_scale * item_q.first_value;

	// second multiply: drop the fraction, clip to q16.16, times the second feature value
	assign sh1    = p1_q[PROD_W-1:FRAC_BITS];
	assign fits1  = (&sh1[INC_W-1:Q_W-1]) || !(|sh1[INC_W-1:Q_W-1]);
	assign s_clip = fits1 ? sh1[Q_W-1:0] : (sh1[INC_W-1] ? Q_MIN : Q_MAX);
	assign p2_d   = s_clip * item_q.second_value;

	// accumulate and clip
	assign incr  = (item_q.func == FUNC_QUAD) ? p2_q[PROD_W-1:FRAC_BITS]
	                                          : p1_q[PROD_W-1:FRAC_BITS];
	assign sum   = (INC_W + 1)'(rdata_q) + (INC_W + 1)'(incr);
	assign fits2 = (&sum[INC_W:Q_W-1]) || !(|sum[INC_W:Q_W-1]);
	assign new_w = fits2 ? sum[Q_W-1:0] : (sum[INC_W] ? Q_MIN : Q_MAX);

	// reads, other codes and zero steps leave the weight alone
	assign do_update = ((item_q.func == FUNC_LINEAR) || (item_q.func == FUNC_QUAD))
	                   && (item_q.step_scale != '0);
	assign sat_out   = do_update && (sat1_q || !fits2);
	assign w_out     = do_update ? new_w : rdata_q;
	assign addr_wide = {{(INDEX_W - AW){1'b0}}, addr_q};

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = new_w;
		unique case (state_q)
			ST_CLEAR: begin
				// zero one entry per cycle
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (&clr_addr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				// hold until the output register can take the word
				if (out_free) begin
					out_load = 1'b1;
					mem_we   = do_update;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// clearing pointer, output valid, configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			out_valid_q  <= 1'b0;
			index_mask_q <= MASK_RESET;
			hash_mult_q  <= HASH_MULT_RESET;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INDEX_MASK: index_mask_q <= cfg_data[MASK_W-1:0];
					REG_HASH_MULT:  hash_mult_q  <= cfg_data[INDEX_W-1:0];
					default:        ;
				endcase
			end
		end
	end

	// item pipeline registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= in_data;
		end
		if (state_q == ST_HASH) begin
			addr_q <= addr_d;
			p1_q   <= p1_d;
		end
		if (state_q == ST_MUL) begin
			p2_q   <= p2_d;
			sat1_q <= !fits1 && (item_q.func == FUNC_QUAD);
		end
		if (out_load) begin
			out_q.entry_address <= addr_wide[ADDR_OUT_W-1:0];
			out_q.weight_value  <= w_out;
			out_q.saturated     <= sat_out;
		end
	end

	// weight memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			weight_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			rdata_q <= weight_mem[addr_q];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`HSWU_ASSERT_NOW(a_mem_we_state, mem_we,
		(state_q == ST_CLEAR) || (state_q == ST_WRITE),
		"memory written outside clear or write-back")
	`HSWU_ASSERT_NEXT(a_accept_to_hash, in_accept, state_q == ST_HASH,
		"accepted word did not start hashing")
	`HSWU_ASSERT_NEXT(a_load_shows, out_load, out_valid,
		"finished word not shown on output")
	`HSWU_ASSERT_NEXT(a_wb_matches_out, mem_we && (state_q == ST_WRITE),
		out_data.weight_value == $past(mem_wdata),
		"written weight differs from output word")
	`HSWU_ASSERT_NOW(a_sat_needs_write, out_load && sat_out, mem_we,
		"saturation reported without an update")

endmodule

`default_nettype wire
